// ===== rtl/wcl_pkg.sv =====
`timescale 1ns / 1ps
package wcl_pkg;
    localparam int MAX_IN        = 16;
    localparam int MAX_OUT       = 16;
    localparam int MAX_WIN       = 8;
    localparam int MAX_POSITIONS = 4096;

    localparam int CH_W   = 4;   // input channel index bits
    localparam int OC_W   = 4;   // output channel index bits
    localparam int COL_W  = 3;   // history column index bits
    localparam int ROW_W  = 7;   // weight row bits
    localparam int POS_W  = 12;
    localparam int ACC_W  = 40;
    localparam int HADR_W = COL_W + CH_W;
    localparam int WADR_W = ROW_W + OC_W;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_SAMPLE = 2'd1;
    localparam logic [1:0] CMD_PAD    = 2'd2;

    localparam logic [1:0] REG_IN_CH  = 2'd0;
    localparam logic [1:0] REG_OUT_CH = 2'd1;
    localparam logic [1:0] REG_WINDOW = 2'd2;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    // clamp a register value into 1..hi
    function automatic logic [4:0] clamp5(input logic [4:0] v, input logic [4:0] hi);
        logic [4:0] r;
        r = v;
        if (v == 5'd0) r = 5'd1;
        else if (v > hi) r = hi;
        return r;
    endfunction
endpackage

// ===== rtl/wide_conv1d_layer_forward.sv =====
`timescale 1ns / 1ps
// Channel  | Dir | Handshake              | Contents
// s_axis   | in  | tvalid/tready          | tdata: weight_row, weight_col, value; tuser: command, first
// m_axis   | out | tvalid/tready          | tdata: out_channel, out_position, result; tlast: last
// cfg      | in  | i_cfg_we               | i_cfg_idx, i_cfg_data
// A load, or a sample that does not finish a column, is taken without leaving IDLE.
// A column finish or pad runs one MAC per cycle from the two memories,
// window*in_channels MACs per output channel, drained before each result is loaded.
// The output register holds a result while the next channel is summed; a stalled
// output holds the sequencer before the next load. Reset clears the history valid
// bits, counters and registers; weights are undefined until loaded.
module wide_conv1d_layer_forward (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // weight_row[6:0], weight_col[10:7], value[26:11]
    input  logic [2:0]  s_axis_tuser,   // command[1:0], first[2]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // out_channel[3:0], out_position[15:4], result[55:16]
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [4:0]  i_cfg_data
);
    localparam int HDEPTH = wcl_pkg::MAX_WIN * wcl_pkg::MAX_IN;
    localparam int WDEPTH = wcl_pkg::MAX_IN * wcl_pkg::MAX_WIN * wcl_pkg::MAX_OUT;

    // input fields
    logic [wcl_pkg::ROW_W-1:0] w_row;
    logic [wcl_pkg::OC_W-1:0]  w_col;
    logic signed [15:0]        w_value;
    logic [1:0]                w_cmd;
    logic                      w_first;
    assign w_row   = s_axis_tdata[6:0];
    assign w_col   = s_axis_tdata[10:7];
    assign w_value = s_axis_tdata[26:11];
    assign w_cmd   = s_axis_tuser[1:0];
    assign w_first = s_axis_tuser[2];

    // configuration
    logic [4:0] r_in_ch, r_out_ch;
    logic [3:0] r_win;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ch  <= 5'd1;
            r_out_ch <= 5'd1;
            r_win    <= 4'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                wcl_pkg::REG_IN_CH:  r_in_ch  <= i_cfg_data;
                wcl_pkg::REG_OUT_CH: r_out_ch <= i_cfg_data;
                wcl_pkg::REG_WINDOW: r_win    <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    logic [4:0] w_ic, w_oc, w_w;
    assign w_ic = wcl_pkg::clamp5(r_in_ch, 5'(wcl_pkg::MAX_IN));
    assign w_oc = wcl_pkg::clamp5(r_out_ch, 5'(wcl_pkg::MAX_OUT));
    assign w_w  = wcl_pkg::clamp5({1'b0, r_win}, 5'(wcl_pkg::MAX_WIN));

    // control state
    logic [1:0]                r_state;
    logic [wcl_pkg::CH_W-1:0]  r_ch;
    logic [wcl_pkg::POS_W-1:0] r_pos, r_epos;
    logic [wcl_pkg::COL_W-1:0] r_head, r_colp, r_col0;
    logic [HDEPTH-1:0]         r_hval;
    logic [wcl_pkg::OC_W-1:0]  r_j;
    logic [wcl_pkg::CH_W-1:0]  r_c;
    logic [wcl_pkg::COL_W-1:0] r_t;
    logic [wcl_pkg::ROW_W-1:0] r_row;
    logic                      r_v1, r_v2, r_hv1;
    logic signed [15:0]        r_hrd, r_wrd;
    logic signed [31:0]        r_prod;
    logic signed [wcl_pkg::ACC_W-1:0] r_acc;
    logic                      r_ovalid;

    logic w_accept, w_take, w_oload;
    assign s_axis_tready = (r_state == wcl_pkg::ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_take        = r_ovalid && m_axis_tready;
    assign w_oload       = (r_state == wcl_pkg::ST_OUT) && (!r_ovalid || m_axis_tready);

    // sample bookkeeping
    logic [wcl_pkg::CH_W-1:0]  w_ch;
    logic [wcl_pkg::COL_W-1:0] w_newhead;
    logic                      w_shift, w_emit, w_hwe;
    logic [wcl_pkg::POS_W-1:0] w_pos;
    always_comb begin
        w_ch      = w_first ? '0 : r_ch;
        w_pos     = (w_first && w_cmd == wcl_pkg::CMD_SAMPLE) ? '0 : r_pos;
        w_shift   = 1'b0;
        w_emit    = 1'b0;
        w_hwe     = 1'b0;
        if (w_accept) begin
            case (w_cmd)
                wcl_pkg::CMD_SAMPLE: begin
                    w_shift = (w_ch == '0);
                    w_hwe   = 1'b1;
                    w_emit  = ({1'b0, w_ch} + 5'd1) >= w_ic;
                end
                wcl_pkg::CMD_PAD: begin
                    w_shift = 1'b1;
                    w_emit  = 1'b1;
                end
                default: ;
            endcase
        end
        w_newhead = w_shift ? r_head + 1'b1 : r_head;
    end

    // history memory, ring of columns, entries valid only once written
    logic [15:0] r_hmem [HDEPTH];
    logic [wcl_pkg::HADR_W-1:0] w_hwadr, w_hradr;
    assign w_hwadr = {w_newhead, w_ch};
    assign w_hradr = {r_colp, r_c};
    always_ff @(posedge i_clk) begin
        if (w_hwe) r_hmem[w_hwadr] <= w_value;
        r_hrd <= r_hmem[w_hradr];
    end

    // weight memory, addressed by row and output channel
    logic [15:0] r_wmem [WDEPTH];
    logic [wcl_pkg::WADR_W-1:0] w_wadr;
    assign w_wadr = {r_row, r_j};
    always_ff @(posedge i_clk) begin
        if (w_accept && w_cmd == wcl_pkg::CMD_LOAD) r_wmem[{w_row, w_col}] <= w_value;
        r_wrd <= r_wmem[w_wadr];
    end

    // valid bits: clear on a first sample, clear new column on shift, set on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hval <= '0;
        end else if (w_accept && w_cmd != wcl_pkg::CMD_LOAD) begin
            logic [HDEPTH-1:0] v;
            v = r_hval;
            if (w_first && w_cmd == wcl_pkg::CMD_SAMPLE) v = '0;
            if (w_shift) begin
                for (int k = 0; k < wcl_pkg::MAX_IN; k++)
                    v[{w_newhead, wcl_pkg::CH_W'(k)}] = 1'b0;
            end
            if (w_hwe) v[w_hwadr] = 1'b1;
            r_hval <= v;
        end
    end

    // sequencer
    logic w_last_c, w_last_t, w_last_j;
    assign w_last_c = ({1'b0, r_c} == w_ic - 5'd1);
    assign w_last_t = ({2'b0, r_t} == w_w - 5'd1);
    assign w_last_j = ({1'b0, r_j} == w_oc - 5'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wcl_pkg::ST_IDLE;
            r_ch    <= '0;
            r_pos   <= '0;
            r_head  <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end else begin
            r_v1 <= (r_state == wcl_pkg::ST_RUN);
            r_v2 <= r_v1;
            case (r_state)
                wcl_pkg::ST_IDLE: begin
                    if (w_accept && w_cmd != wcl_pkg::CMD_LOAD && w_cmd != wcl_pkg::CMD_SAMPLE
                        && w_cmd != wcl_pkg::CMD_PAD) begin
                        r_state <= wcl_pkg::ST_IDLE;
                    end else if (w_accept && w_cmd != wcl_pkg::CMD_LOAD) begin
                        r_head <= w_newhead;
                        if (w_emit) begin
                            r_ch    <= '0;
                            r_epos  <= w_pos;
                            // advance the position, hold it at the top
                            if (w_pos != wcl_pkg::POS_W'(wcl_pkg::MAX_POSITIONS - 1))
                                r_pos <= w_pos + 1'b1;
                            else
                                r_pos <= w_pos;
                            r_col0  <= w_newhead + 1'b1 - w_w[wcl_pkg::COL_W-1:0];
                            r_colp  <= w_newhead + 1'b1 - w_w[wcl_pkg::COL_W-1:0];
                            r_j     <= '0;
                            r_c     <= '0;
                            r_t     <= '0;
                            r_row   <= '0;
                            r_state <= wcl_pkg::ST_RUN;
                        end else begin
                            r_ch  <= w_ch + 1'b1;
                            r_pos <= w_pos;
                        end
                    end
                end
                wcl_pkg::ST_RUN: begin
                    // step through taps and channels, one address pair per cycle
                    r_row <= r_row + 1'b1;
                    if (w_last_c) begin
                        r_c    <= '0;
                        r_t    <= r_t + 1'b1;
                        r_colp <= r_colp + 1'b1;
                        if (w_last_t) r_state <= wcl_pkg::ST_DRAIN;
                    end else begin
                        r_c <= r_c + 1'b1;
                    end
                end
                wcl_pkg::ST_DRAIN: begin
                    if (!r_v1 && !r_v2) r_state <= wcl_pkg::ST_OUT;
                end
                wcl_pkg::ST_OUT: begin
                    if (w_oload) begin
                        if (w_last_j) begin
                            r_state <= wcl_pkg::ST_IDLE;
                        end else begin
                            r_j     <= r_j + 1'b1;
                            r_c     <= '0;
                            r_t     <= '0;
                            r_row   <= '0;
                            r_colp  <= r_col0;
                            r_state <= wcl_pkg::ST_RUN;
                        end
                    end
                end
                default: r_state <= wcl_pkg::ST_IDLE;
            endcase
        end
    end

    // multiply and accumulate; unwritten history reads as zero
    always_ff @(posedge i_clk) begin
        r_hv1  <= r_hval[w_hradr];
        r_prod <= r_hv1 ? r_hrd * r_wrd : 32'sd0;
        if (r_state == wcl_pkg::ST_IDLE || w_oload) r_acc <= '0;
        else if (r_v2) r_acc <= r_acc + wcl_pkg::ACC_W'(r_prod);
    end

    // output register
    logic [wcl_pkg::OC_W-1:0]  r_och;
    logic [wcl_pkg::POS_W-1:0] r_opos;
    logic [wcl_pkg::ACC_W-1:0] r_ores;
    logic                      r_olast;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_oload) begin
            r_ovalid <= 1'b1;
        end else if (w_take) begin
            r_ovalid <= 1'b0;
        end
        if (w_oload) begin
            r_och   <= r_j;
            r_opos  <= r_epos;
            r_ores  <= r_acc;
            r_olast <= w_last_j;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_ores, r_opos, r_och};
    assign m_axis_tlast  = r_olast;
endmodule
